/* hw/rtl/moving_sum_peak_detector_core_defines.svh */
// Assertion macros shared by the moving-sum peak detector RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MOVING_SUM_PEAK_DETECTOR_CORE_DEFINES_SVH
`define MOVING_SUM_PEAK_DETECTOR_CORE_DEFINES_SVH

// Check that expr holds at every clock edge out of reset.
`define MSPD_ASSERT(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define MSPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define MSPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mspd_pkg.sv */
// Constants and register codes of the moving-sum peak detector.
// Depends on nothing; used by every RTL module of the block.
package mspd_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SCORE_W = 21;
	localparam int THRESH_W = 22;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int DEFAULT_WINDOW_LENGTH = 64;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	typedef enum logic [0:0] {
		REG_THRESHOLD = 1'b0
	} reg_idx_t;

endpackage

/* hw/rtl/mspd_cell.sv */
// One cell of the sample delay line: holds a sample, passes it on per transaction.
// Depends on mspd_pkg.
module mspd_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 shift_en,
	input  logic signed [mspd_pkg::SAMPLE_W-1:0] d,
	output logic signed [mspd_pkg::SAMPLE_W-1:0] q
);

	logic signed [mspd_pkg::SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

/* hw/rtl/mspd_peak.sv */
// Score stage: clamps the window sum, compares with the threshold and the score history, holds the result.
// Depends on mspd_pkg.
module mspd_peak #(
	parameter int SUM_W = mspd_pkg::SAMPLE_W + 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic signed [SUM_W-1:0]              sum,
	input  logic        [mspd_pkg::THRESH_W-1:0] thresh_level,
	output logic                                 peak_flag,
	output logic        [mspd_pkg::SCORE_W-1:0]  score
);

	localparam int EXT_W = (SUM_W > mspd_pkg::SCORE_W + 1) ? SUM_W : mspd_pkg::SCORE_W + 1;

	logic signed [EXT_W-1:0]             sum_ext;
	logic        [mspd_pkg::SCORE_W-1:0] score_next;
	logic                                flag_next;
	logic        [mspd_pkg::SCORE_W-1:0] prev_score_q;
	logic        [mspd_pkg::SCORE_W-1:0] before_prev_q;
	logic        [mspd_pkg::SCORE_W-1:0] score_q;
	logic                                flag_q;

	assign sum_ext = EXT_W'(sum);

	always_comb begin
		if (sum_ext[EXT_W-1]) begin
			score_next = '0;
		end else if ($unsigned(sum_ext) > EXT_W'(mspd_pkg::SCORE_MAX)) begin
			score_next = mspd_pkg::SCORE_MAX;
		end else begin
			score_next = sum_ext[mspd_pkg::SCORE_W-1:0];
		end
	end

	assign flag_next = (mspd_pkg::THRESH_W'(score_next) > thresh_level) &&
		(score_next < prev_score_q) && (before_prev_q < prev_score_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_score_q  <= '0;
			before_prev_q <= '0;
		end else if (adv) begin
			prev_score_q  <= score_next;
			before_prev_q <= prev_score_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			score_q <= score_next;
			flag_q  <= flag_next;
		end
	end

	assign score     = score_q;
	assign peak_flag = flag_q;

endmodule

/* hw/rtl/moving_sum_peak_detector_core.sv */
// Moving-sum peak detector: delay line of cells, running sum, score and peak flag.
// An accepted sample updates the running-sum register, then the score and flag registers.
// Throughput: one transaction per cycle when not stalled, set by the single running-sum adder.
// Reset clears the delay line, running sum, score history, threshold and valid bits.
// Depends on mspd_pkg, mspd_cell, mspd_peak and the assertion macro header.
`include "moving_sum_peak_detector_core_defines.svh"
module moving_sum_peak_detector_core #(
	parameter int WINDOW_LENGTH = mspd_pkg::DEFAULT_WINDOW_LENGTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic        [mspd_pkg::ADDR_W-1:0]   paddr,
	input  logic        [mspd_pkg::DATA_W-1:0]   pwdata,
	output logic        [mspd_pkg::DATA_W-1:0]   prdata,
	output logic                                 pready,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [mspd_pkg::SAMPLE_W-1:0] sample,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic                                 peak_flag,
	output logic        [mspd_pkg::SCORE_W-1:0]  score
);

	localparam int SUM_W = mspd_pkg::SAMPLE_W + $clog2(WINDOW_LENGTH);

	logic signed [mspd_pkg::SAMPLE_W-1:0] tap [WINDOW_LENGTH];
	logic signed [mspd_pkg::SAMPLE_W-1:0] oldest;
	logic signed [SUM_W-1:0]              sum_s1;
	logic                                 valid_s1;
	logic                                 valid_q;
	logic        [mspd_pkg::THRESH_W-1:0] threshold_q;
	logic                                 accept;
	logic                                 adv_s2;
	logic                                 cfg_write;
	mspd_pkg::reg_idx_t                   reg_idx;

	assign adv_s2       = valid_s1 && (!valid_q || !result_stall);
	assign sample_stall = valid_s1 && !adv_s2;
	assign accept       = sample_valid && !sample_stall;

	mspd_cell u_cell_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (accept),
		.d        (sample),
		.q        (tap[0])
	);

	for (genvar i = 1; i < WINDOW_LENGTH; i++) begin : g_cell
		mspd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.d        (tap[i-1]),
			.q        (tap[i])
		);
	end

	assign oldest = tap[WINDOW_LENGTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_s1   <= '0;
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				sum_s1 <= sum_s1 + SUM_W'(sample) - SUM_W'(oldest);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	mspd_peak #(
		.SUM_W (SUM_W)
	) u_peak (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv_s2),
		.sum          (sum_s1),
		.thresh_level (threshold_q),
		.peak_flag    (peak_flag),
		.score        (score)
	);

	assign result_valid = valid_q;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_idx   = mspd_pkg::reg_idx_t'(paddr[mspd_pkg::ADDR_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_write && reg_idx == mspd_pkg::REG_THRESHOLD) begin
			threshold_q <= pwdata[mspd_pkg::THRESH_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			mspd_pkg::REG_THRESHOLD: prdata = mspd_pkg::DATA_W'(threshold_q);
			default:                 prdata = '0;
		endcase
		if (paddr[mspd_pkg::ADDR_W-1]) begin
			prdata = '0;
		end
	end

	`MSPD_ASSERT_SAME(a_stall_only_when_full, clk, arst_n, sample_stall, valid_s1 && valid_q, "input stalled with a free stage")
	`MSPD_ASSERT_NEXT(a_adv_fills_output, clk, arst_n, adv_s2, result_valid, "advanced transaction not presented")
	`MSPD_ASSERT_NEXT(a_sum_holds_on_equal, clk, arst_n, accept && (sample == oldest), $stable(sum_s1), "running sum moved for equal samples")
	`MSPD_ASSERT(a_flag_needs_score, clk, arst_n, !(result_valid && peak_flag) || (score != '0), "peak flag with zero score")

endmodule
